// ===== hw/rtl/rpa_pkg.sv =====
// Shared types and constants for the refcounted page allocator.
`default_nettype none
package rpa_pkg;

  localparam int PAGE_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int REFOUT_W   = 8;
  localparam int FREE_W     = 13;
  localparam int BASE_W     = 12;
  localparam int LIMIT_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_ADDREF  = 2'd2,
    MODE_SEED    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_SAT   = 3'd3,
    ST_DFREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PAGE_W-1:0] page;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   page_out;
    logic [STATUS_W-1:0] status;
    logic [REFOUT_W-1:0] ref_count;
    logic [FREE_W-1:0]   free_pages;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/refcounted_page_allocator.sv =====
// Top level of the refcounted page allocator: control, count table and free stack.
`default_nettype none
// An item is taken in the idle cycle and both memories are read on that edge; the result is
//   registered in the execute state, and out_valid rises when that state fires, which it
//   does not do while an earlier result is still waiting.
// A new item is not taken until the last one is written back (read-modify-write of the count RAM).
// Reset (synchronous, active low) clears control state and then sweeps the count RAM to zero,
//   one entry a cycle, through all MAX_PAGES entries; no item is taken until the sweep ends.
//   Configuration writes are taken throughout.
module refcounted_page_allocator #(
  parameter int MAX_PAGES  = 4096,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input item channel
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire rpa_pkg::in_item_t               in_item,
  // result item channel
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      rpa_pkg::out_item_t              out_item,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_PAGES);      // RAM address width
  localparam int DW = $clog2(MAX_PAGES + 1);  // stack depth, holds MAX_PAGES itself

  localparam logic [DW-1:0]         DEPTH_FULL = DW'(MAX_PAGES);
  localparam logic [AW-1:0]         CLR_LAST   = AW'(MAX_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rpa_pkg::BASE_W-1:0]  base_r;
  logic [rpa_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= rpa_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpa_pkg::CFG_BASE:  base_r  <= cfg_wdata[rpa_pkg::BASE_W-1:0];
        rpa_pkg::CFG_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State machine: clear sweep, idle (accepting), execute (write back)
  // ---------------------------------------------------------------------------
  rpa_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_idx_r;
  logic            out_valid_r;
  logic            accept;
  logic            fire;      // execute cycle that commits and loads the output register
  logic            clr_we;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpa_pkg::S_CLEAR: if (clr_idx_r == CLR_LAST) state_nxt = rpa_pkg::S_IDLE;
      rpa_pkg::S_IDLE:  if (accept) state_nxt = rpa_pkg::S_EXEC;
      rpa_pkg::S_EXEC:  if (fire) state_nxt = rpa_pkg::S_IDLE;
      default:          state_nxt = rpa_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    fire     = 1'b0;
    clr_we   = 1'b0;
    unique case (state_r)
      rpa_pkg::S_CLEAR: clr_we = 1'b1;
      rpa_pkg::S_IDLE:  in_ready = 1'b1;
      // hold the item while an earlier result is still waiting
      rpa_pkg::S_EXEC:  fire = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rpa_pkg::S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture at acceptance; range check uses the window as it stands then
  // ---------------------------------------------------------------------------
  rpa_pkg::mode_t              mode_r;
  logic [rpa_pkg::PAGE_W-1:0]  page_r;
  logic                        in_range_r;
  logic                        in_range;

  assign in_range = (in_item.page >= base_r) &&
                    (rpa_pkg::LIMIT_W'(in_item.page) < limit_r) &&
                    (32'(in_item.page) < 32'(MAX_PAGES));

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= rpa_pkg::mode_t'(in_item.mode);
      page_r     <= in_item.page;
      in_range_r <= in_range;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: count table and free stack
  // ---------------------------------------------------------------------------
  logic [DW-1:0]              depth_r, depth_nxt;
  logic                       ref_we, ref_we_op;
  logic [AW-1:0]              ref_waddr, ref_waddr_op;
  logic [COUNT_BITS-1:0]      ref_wdata, ref_wdata_op;
  logic [COUNT_BITS-1:0]      cnt;
  logic                       stk_we;
  logic [rpa_pkg::PAGE_W-1:0] top;

  // clear sweep owns the count RAM write port until it ends
  assign ref_we    = clr_we || ref_we_op;
  assign ref_waddr = clr_we ? clr_idx_r : ref_waddr_op;
  assign ref_wdata = clr_we ? '0 : ref_wdata_op;

  rpa_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (COUNT_BITS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (accept),
    .raddr (AW'(32'(in_item.page))),
    .rdata (cnt)
  );

  // pop reads the entry below the top; push writes at the current depth
  rpa_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (rpa_pkg::PAGE_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (AW'(depth_r)),
    .wdata (page_r),
    .re    (accept),
    .raddr (AW'(depth_r - DW'(1))),
    .rdata (top)
  );

  // ---------------------------------------------------------------------------
  // Execute: decide the operation from the read data, write back, form result
  // ---------------------------------------------------------------------------
  logic                       empty, full;
  rpa_pkg::status_t           res_status;
  logic [rpa_pkg::PAGE_W-1:0] res_page;
  logic [COUNT_BITS-1:0]      res_cnt;
  logic                       do_ref_wr, do_push;

  assign empty = (depth_r == '0);
  assign full  = (depth_r == DEPTH_FULL);

  always_comb begin
    res_status   = rpa_pkg::ST_OK;
    res_page     = page_r;
    res_cnt      = cnt;
    depth_nxt    = depth_r;
    do_ref_wr    = 1'b0;
    do_push      = 1'b0;
    ref_wdata_op = '0;
    ref_waddr_op = AW'(32'(page_r));
    unique case (mode_r)
      rpa_pkg::MODE_ALLOC: begin
        if (empty) begin
          res_status = rpa_pkg::ST_EMPTY;
          res_page   = '0;
          res_cnt    = '0;
        end else begin
          depth_nxt    = depth_r - DW'(1);
          res_page     = top;
          res_cnt      = CNT_ONE;
          do_ref_wr    = 1'b1;
          ref_wdata_op = CNT_ONE;
          ref_waddr_op = AW'(32'(top));
        end
      end
      rpa_pkg::MODE_RELEASE: begin
        if (!in_range_r) begin
          res_status = rpa_pkg::ST_RANGE;
          res_cnt    = '0;
        end else if (cnt == '0) begin
          res_status = rpa_pkg::ST_DFREE;   // release of an unreferenced page
        end else if (cnt != CNT_ONE) begin
          res_cnt      = cnt - CNT_ONE;
          do_ref_wr    = 1'b1;
          ref_wdata_op = cnt - CNT_ONE;
        end else if (full) begin
          res_status = rpa_pkg::ST_DFREE;
        end else begin
          // last reference gone: page back on the stack
          res_cnt   = '0;
          do_ref_wr = 1'b1;
          do_push   = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
      end
      rpa_pkg::MODE_ADDREF: begin
        if (!in_range_r) begin
          res_status = rpa_pkg::ST_RANGE;
          res_cnt    = '0;
        end else if (cnt == CNT_MAX) begin
          res_status = rpa_pkg::ST_SAT;
        end else begin
          res_cnt      = cnt + CNT_ONE;
          do_ref_wr    = 1'b1;
          ref_wdata_op = cnt + CNT_ONE;
        end
      end
      rpa_pkg::MODE_SEED: begin
        if (!in_range_r) begin
          res_status = rpa_pkg::ST_RANGE;
          res_cnt    = '0;
        end else if (full) begin
          res_status = rpa_pkg::ST_DFREE;
        end else begin
          res_cnt   = '0;
          do_ref_wr = 1'b1;
          do_push   = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
      end
      default: ;
    endcase
  end

  assign ref_we_op = fire && do_ref_wr;
  assign stk_we    = fire && do_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (fire) begin
      depth_r <= depth_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  rpa_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r.page_out   <= res_page;
      out_item_r.status     <= res_status;
      out_item_r.ref_count  <= rpa_pkg::REFOUT_W'(res_cnt);
      out_item_r.free_pages <= rpa_pkg::FREE_W'(depth_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rpa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module rpa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
